### src/sac_pkg.sv
`default_nettype none
package sac_pkg;

  localparam int ADDR_W = 64;
  localparam int TAG_W  = 63;
  localparam int CNT_W  = 64;
  localparam int CFG_W  = 4;
  localparam int CIDX_W = 2;

  // result codes
  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  // register indexes
  localparam logic [CIDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_WAYS       = 2'd2;

endpackage
`default_nettype wire

### src/sac_if.sv
`default_nettype none
interface sac_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [sac_pkg::ADDR_W-1:0] address;
  modport source (output valid, action, address, input ready);
  modport sink   (input valid, action, address, output ready);
endinterface

interface sac_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                outcome;
  logic                      victim_was_dirty;
  logic [sac_pkg::CNT_W-1:0] hit_count;
  logic [sac_pkg::CNT_W-1:0] miss_count;
  logic [sac_pkg::CNT_W-1:0] eviction_count;
  logic [sac_pkg::CNT_W-1:0] dirty_bytes_now;
  logic [sac_pkg::CNT_W-1:0] writeback_bytes;
  modport source (output valid, outcome, victim_was_dirty, hit_count, miss_count,
                  eviction_count, dirty_bytes_now, writeback_bytes, input ready);
  modport sink   (input valid, outcome, victim_was_dirty, hit_count, miss_count,
                  eviction_count, dirty_bytes_now, writeback_bytes, output ready);
endinterface

interface sac_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [sac_pkg::CIDX_W-1:0] index;
  logic [sac_pkg::CFG_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### src/sac_ram.sv
`default_nettype none
module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and register the read word
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### src/set_assoc_cache_lru_writeback.sv
// Tag side of a set-associative write-back cache with true LRU replacement.
// Input channel in_ch carries one access word: action (0 load, 1 store) and a
// byte address (bit 63 ignored). Output channel out_ch gives one result word
// per access: outcome (hit, fill of a free way, eviction), whether the victim
// was dirty, and the running hit, miss, eviction and dirty byte counts.
// cfg_ch writes set_bits, block_bits and ways_in_use; write it only while idle.
// An access first reads the set row from the tag RAM, then compares the ways
// in use, updates ages and writes the row back. The tag RAM is read once per
// access, and a new access is taken only after the last one has written back.
// The result sits in an output register; the next access is taken while it
// waits, and its lookup holds until the receiver takes the pending word.
// Reset (rst_n low, synchronous) clears the counters, the control registers
// (ways_in_use to 1) and one valid flag per set row, so every line reads as
// invalid and clean, age zero; no clearing pass, ready right after reset.
`default_nettype none
module set_assoc_cache_lru_writeback #(
  parameter int MAX_SET_BITS   = 8,
  parameter int MAX_WAYS       = 8,
  parameter int MAX_BLOCK_BITS = 12
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sac_in_if.sink     in_ch,
  sac_out_if.source  out_ch,
  sac_cfg_if.sink    cfg_ch
);

  localparam int SW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int DEPTH = 1 << MAX_SET_BITS;
  localparam int AGE_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WW    = AGE_W;
  localparam int EW    = sac_pkg::TAG_W + 2 + AGE_W;
  localparam int RW    = MAX_WAYS * EW;
  localparam logic [AGE_W-1:0] MAX_AGE = AGE_W'(MAX_WAYS - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic [0:0] state_r, state_nxt;
  logic [sac_pkg::CFG_W-1:0] set_bits_r, block_bits_r, ways_r;
  logic [DEPTH-1:0] row_vld_r;
  logic [SW-1:0] set_r;
  logic [sac_pkg::TAG_W-1:0] tag_r;
  logic store_r;
  logic out_valid_r;
  logic [1:0] outcome_r, outcome_nxt;
  logic vdirty_r, vdirty_nxt;
  logic [sac_pkg::CNT_W-1:0] hits_r, misses_r, evicts_r, dbytes_r, devict_r;
  logic [sac_pkg::CNT_W-1:0] dbytes_nxt, devict_nxt;

  logic [5:0] s_eff, b_eff, n_eff;
  logic [sac_pkg::CNT_W-1:0] bsize;
  logic [sac_pkg::TAG_W-1:0] in_addr, in_tag;
  logic [SW-1:0] in_set;
  logic accept, go;
  logic [RW-1:0] rd_row, wr_row;

  // clamp the registers to their usable ranges
  always_comb begin
    int s, b, n;
    s = int'(set_bits_r);
    b = int'(block_bits_r);
    n = (ways_r == '0) ? 1 : int'(ways_r);
    if (s > MAX_SET_BITS) s = MAX_SET_BITS;
    if (b > MAX_BLOCK_BITS) b = MAX_BLOCK_BITS;
    if (n > MAX_WAYS) n = MAX_WAYS;
    s_eff = 6'(s);
    b_eff = 6'(b);
    n_eff = 6'(n);
  end

  assign bsize = sac_pkg::CNT_W'(1) << b_eff;

  // split the incoming address
  assign in_addr = in_ch.address[sac_pkg::TAG_W-1:0];
  assign in_tag  = in_addr >> (s_eff + b_eff);
  assign in_set  = SW'((in_addr >> b_eff) & ((sac_pkg::TAG_W'(1) << s_eff) - 1'b1));

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign go           = (state_r == ST_LOOK) && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  sac_ram #(.WIDTH(RW), .DEPTH(DEPTH), .AW(SW)) u_ram (
    .clk     (clk),
    .wr_en   (go),
    .wr_addr (set_r),
    .wr_data (wr_row),
    .rd_en   (accept),
    .rd_addr (in_set),
    .rd_data (rd_row)
  );

  // lookup, LRU update and counter update for the row just read
  always_comb begin
    logic [MAX_WAYS-1:0] vld, dty, inuse;
    logic [AGE_W-1:0] age [MAX_WAYS];
    logic [sac_pkg::TAG_W-1:0] tg [MAX_WAYS];
    logic rv, hit, have_free, was_valid, vd;
    logic [WW-1:0] hit_w, free_w, vic_w, w;
    logic [AGE_W-1:0] old;
    rv = row_vld_r[set_r];
    hit = 1'b0;
    have_free = 1'b0;
    hit_w = '0;
    free_w = '0;
    vic_w = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      tg[i]    = rd_row[i*EW +: sac_pkg::TAG_W];
      vld[i]   = rv & rd_row[i*EW + sac_pkg::TAG_W];
      dty[i]   = rv & rd_row[i*EW + sac_pkg::TAG_W + 1];
      age[i]   = rv ? rd_row[i*EW + sac_pkg::TAG_W + 2 +: AGE_W] : '0;
      inuse[i] = (6'(i) < n_eff);
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (inuse[i] && vld[i]) begin
        if (!hit && tg[i] == tag_r) begin
          hit = 1'b1;
          hit_w = WW'(i);
        end
        if (age[i] > age[vic_w]) vic_w = WW'(i);
      end else if (inuse[i] && !have_free) begin
        have_free = 1'b1;
        free_w = WW'(i);
      end
    end
    w = hit ? hit_w : (have_free ? free_w : vic_w);
    was_valid = hit || !have_free;
    old = age[w];
    vd = 1'b0;
    dbytes_nxt = dbytes_r;
    devict_nxt = devict_r;
    if (hit) begin
      outcome_nxt = sac_pkg::OUT_HIT;
      if (store_r && !dty[w]) dbytes_nxt = dbytes_r + bsize;
    end else if (have_free) begin
      outcome_nxt = sac_pkg::OUT_FILL;
      if (store_r) dbytes_nxt = dbytes_r + bsize;
    end else begin
      outcome_nxt = sac_pkg::OUT_EVICT;
      if (dty[w]) begin
        vd = 1'b1;
        devict_nxt = devict_r + bsize;
        if (!store_r) dbytes_nxt = dbytes_r - bsize;
      end else if (store_r) begin
        dbytes_nxt = dbytes_r + bsize;
      end
    end
    vdirty_nxt = vd;
    // promote the chosen way
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (inuse[i] && vld[i] && WW'(i) != w && (!was_valid || age[i] < old)
          && age[i] < MAX_AGE) age[i] = age[i] + 1'b1;
    end
    age[w] = '0;
    if (!hit) tg[w] = tag_r;
    vld[w] = 1'b1;
    if (hit) dty[w] = dty[w] | store_r;
    else dty[w] = store_r;
    for (int i = 0; i < MAX_WAYS; i++) begin
      wr_row[i*EW +: EW] = {age[i], dty[i], vld[i], tg[i]};
    end
  end

  // sequence one access at a time
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_LOOK;
      ST_LOOK: if (go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      set_bits_r   <= '0;
      block_bits_r <= '0;
      ways_r       <= sac_pkg::CFG_W'(1);
      row_vld_r    <= '0;
      out_valid_r  <= 1'b0;
      hits_r       <= '0;
      misses_r     <= '0;
      evicts_r     <= '0;
      dbytes_r     <= '0;
      devict_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          sac_pkg::CFG_SET_BITS:   set_bits_r   <= cfg_ch.data;
          sac_pkg::CFG_BLOCK_BITS: block_bits_r <= cfg_ch.data;
          sac_pkg::CFG_WAYS:       ways_r       <= cfg_ch.data;
          default: ;
        endcase
      end
      if (go) begin
        row_vld_r[set_r] <= 1'b1;
        out_valid_r      <= 1'b1;
        dbytes_r         <= dbytes_nxt;
        devict_r         <= devict_nxt;
        if (outcome_nxt == sac_pkg::OUT_HIT) hits_r <= hits_r + 1'b1;
        else misses_r <= misses_r + 1'b1;
        if (outcome_nxt == sac_pkg::OUT_EVICT) evicts_r <= evicts_r + 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the access and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      set_r   <= in_set;
      tag_r   <= in_tag;
      store_r <= in_ch.action;
    end
    if (go) begin
      outcome_r <= outcome_nxt;
      vdirty_r  <= vdirty_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.outcome          = outcome_r;
  assign out_ch.victim_was_dirty = vdirty_r;
  assign out_ch.hit_count        = hits_r;
  assign out_ch.miss_count       = misses_r;
  assign out_ch.eviction_count   = evicts_r;
  assign out_ch.dirty_bytes_now  = dbytes_r;
  assign out_ch.writeback_bytes  = devict_r;

endmodule
`default_nettype wire

### src/sac_checker.sv
`default_nettype none
module sac_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [1:0]                outcome,
  input wire logic                      victim_was_dirty,
  input wire logic [sac_pkg::CNT_W-1:0] miss_count,
  input wire logic [sac_pkg::CNT_W-1:0] eviction_count
);

  // a stalled result word stays up
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // only the three result codes appear
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (outcome == sac_pkg::OUT_HIT || outcome == sac_pkg::OUT_FILL ||
                   outcome == sac_pkg::OUT_EVICT))
    else $error("bad outcome code");

  // a dirty victim only comes with an eviction
  a_vdirty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && outcome != sac_pkg::OUT_EVICT |-> !victim_was_dirty)
    else $error("dirty victim without eviction");

  // every eviction is also a miss
  a_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> eviction_count <= miss_count)
    else $error("evictions exceed misses");

endmodule

bind set_assoc_cache_lru_writeback sac_checker u_sac_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .outcome          (out_ch.outcome),
  .victim_was_dirty (out_ch.victim_was_dirty),
  .miss_count       (out_ch.miss_count),
  .eviction_count   (out_ch.eviction_count)
);
`default_nettype wire
